FILE: rtl/core/lfy_pkg.sv
// Shared types and constants of the LCG-driven Fisher-Yates shuffler.
// Used by every module under rtl/core; depends on nothing.
package lfy_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_SEED = 1'b0;
  localparam logic [31:0] SEED_RESET = 32'd1;

  localparam logic [30:0] LCG_MUL = 31'd1103515245;
  localparam logic [30:0] LCG_ADD = 31'd12345;

  typedef struct packed {
    logic [31:0] value;
    logic last;
    logic drop;
  } lfy_entry_t;

  typedef struct packed {
    logic load;
    logic [31:0] value;
  } lfy_seed_t;

endpackage

FILE: rtl/core/lfy_front.sv
// Input side: accepts words and marks each one as stored or dropped.
// Depends on lfy_pkg; feeds lfy_queue.
module lfy_front #(
  parameter int DEPTH = lfy_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,  // element_value
  input  logic                s_tlast,  // last_element
  input  logic                q_full,
  output logic                push,
  output lfy_pkg::lfy_entry_t entry
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic          full_store;

  assign full_store = (count == CW'(DEPTH));
  assign s_tready = !q_full;
  assign push = s_tvalid && s_tready;

  always_comb begin
    entry.value = s_tdata;
    entry.last = s_tlast;
    entry.drop = full_store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (s_tlast) begin
        count <= '0;
      end else if (!full_store) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/lfy_queue.sv
// Short queue of classified words between the front and the back.
// Depends on lfy_pkg.
module lfy_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lfy_pkg::lfy_entry_t push_entry,
  input  logic                pop,
  output lfy_pkg::lfy_entry_t head,
  output logic                full,
  output logic                empty,
  output logic [lfy_pkg::QAW:0] count
);

  lfy_pkg::lfy_entry_t slots [lfy_pkg::QDEPTH];
  logic [lfy_pkg::QAW-1:0] wr_ptr;
  logic [lfy_pkg::QAW-1:0] rd_ptr;

  assign full = (count == (lfy_pkg::QAW + 1)'(lfy_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lfy_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lfy_pkg::QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (lfy_pkg::QAW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (lfy_pkg::QAW + 1)'(1);
      end
    end
  end

endmodule

FILE: rtl/core/lfy_back.sv
// Back side: element store, generator, swap sequencer and output register.
// Depends on lfy_pkg; drains lfy_queue.
module lfy_back #(
  parameter int DEPTH = lfy_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  lfy_pkg::lfy_seed_t  seed,
  input  lfy_pkg::lfy_entry_t head,
  input  logic                q_empty,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,  // shuffled_value
  output logic                m_tlast,  // final_result
  output logic                m_tuser   // overflow_dropped
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [7:0] {
    S_LOAD = 8'b00000001,
    S_ADV  = 8'b00000010,
    S_PICK = 8'b00000100,
    S_RD   = 8'b00001000,
    S_WR1  = 8'b00010000,
    S_WR2  = 8'b00100000,
    S_ERD  = 8'b01000000,
    S_EOUT = 8'b10000000
  } state_t;

  state_t        state;
  logic [CW-1:0] n;
  logic          ovf;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [AW-1:0] k;
  logic [31:0]   gen;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rda;
  logic [31:0]   rdb;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic          ren_a;
  logic          ren_b;
  logic [AW-1:0] ra;

  logic [61:0]      gen_prod;
  logic [30:0]      gen_adv;
  logic [CW-1:0]    ip1;
  logic [30+CW:0]   pick_prod;
  logic [CW-1:0]    n_last;
  logic             is_final;
  logic             out_load;

  assign gen_prod = lfy_pkg::LCG_MUL * gen[30:0];
  assign gen_adv = gen_prod[30:0] + lfy_pkg::LCG_ADD;
  assign ip1 = CW'(i) + CW'(1);
  assign pick_prod = gen[30:0] * ip1;
  assign n_last = head.drop ? n : n + CW'(1);
  assign is_final = (CW'(k) + CW'(1) == n);
  assign out_load = (state == S_EOUT) && (!m_tvalid || m_tready);
  assign pop = (state == S_LOAD) && !q_empty;
  assign ra = (state == S_ERD) ? k : i;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = n[AW-1:0];
    mem_wd = head.value;
    ren_a = 1'b0;
    ren_b = 1'b0;
    case (state)
      S_LOAD: begin
        mem_we = pop && !head.drop;
      end
      S_RD: begin
        ren_a = 1'b1;
        ren_b = 1'b1;
      end
      S_WR1: begin
        mem_we = 1'b1;
        mem_wa = i;
        mem_wd = rdb;
      end
      S_WR2: begin
        mem_we = 1'b1;
        mem_wa = j;
        mem_wd = rda;
      end
      S_ERD: begin
        ren_a = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ren_a) begin
      rda <= mem[ra];
    end
    if (ren_b) begin
      rdb <= mem[j];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rda;
      m_tlast <= is_final;
      m_tuser <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      n <= '0;
      ovf <= 1'b0;
      i <= '0;
      j <= '0;
      k <= '0;
      gen <= lfy_pkg::SEED_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (seed.load) begin
        gen <= seed.value;
      end else if (state == S_ADV) begin
        gen <= {1'b0, gen_adv};
      end
      case (state)
        S_LOAD: begin
          if (pop) begin
            if (head.drop) begin
              ovf <= 1'b1;
            end
            n <= n_last;
            if (head.last) begin
              k <= '0;
              if (n_last > CW'(1)) begin
                i <= AW'(n_last - CW'(1));
                state <= S_ADV;
              end else begin
                state <= S_ERD;
              end
            end
          end
        end
        S_ADV: begin
          state <= S_PICK;
        end
        S_PICK: begin
          j <= pick_prod[30+AW:31];
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WR1;
        end
        S_WR1: begin
          state <= S_WR2;
        end
        S_WR2: begin
          if (i == AW'(1)) begin
            state <= S_ERD;
          end else begin
            i <= i - AW'(1);
            state <= S_ADV;
          end
        end
        S_ERD: begin
          state <= S_EOUT;
        end
        S_EOUT: begin
          if (out_load) begin
            if (is_final) begin
              n <= '0;
              ovf <= 1'b0;
              state <= S_LOAD;
            end else begin
              k <= k + AW'(1);
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/lcg_fisher_yates_shuffler.sv
// Top level of the LCG-driven Fisher-Yates shuffler with its APB register.
// Depends on lfy_pkg, lfy_front, lfy_queue and lfy_back.
//
// Words are taken on the slave stream until one with tlast; up to DEPTH are
// kept and any beyond are dropped, which sets tuser on every word of the
// result. The stored words are then shuffled with a 31-bit LCG (one advance
// per swap) and sent out in order on the master stream, tlast on the final
// one. Words are stored one per cycle while the sequencer is loading; each
// swap is five steps of the single sequencer (advance, pick, read both
// entries, write back twice), since the one-write-port element memory is
// shared; each output word goes through a memory read and then the output
// register, which waits for m_tready. A four-word queue lets input words
// be taken while the previous array is still being shuffled or drained.
// Writing the seed register at address 0 reloads the generator, which
// otherwise keeps running from one array to the next.
module lcg_fisher_yates_shuffler #(
  parameter int DEPTH = lfy_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,  // element_value
  input  logic                        s_tlast,  // last_element
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,  // shuffled_value
  output logic                        m_tlast,  // final_result
  output logic                        m_tuser,  // overflow_dropped
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfy_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lfy_pkg::lfy_entry_t push_entry;
  lfy_pkg::lfy_entry_t head;
  lfy_pkg::lfy_seed_t  seed;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  logic [lfy_pkg::QAW:0] q_count;
  logic [31:0]         seed_reg;
  logic                seed_hit;

  assign pready = 1'b1;
  assign seed_hit = (paddr[2:2] == lfy_pkg::REG_SEED);
  assign seed.load = psel && penable && pwrite && pready && seed_hit;
  assign seed.value = pwdata;
  assign prdata = seed_hit ? seed_reg : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= lfy_pkg::SEED_RESET;
    end else if (seed.load) begin
      seed_reg <= pwdata;
    end
  end

  lfy_front #(.DEPTH(DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  lfy_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty),
    .count      (q_count)
  );

  lfy_back #(.DEPTH(DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .seed     (seed),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> q_count != (lfy_pkg::QAW + 1)'(lfy_pkg::QDEPTH))
    else $error("word pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_count != '0)
    else $error("word popped from an empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> q_count == $past(q_count) + (lfy_pkg::QAW + 1)'(1))
    else $error("queue count lost a pushed word");
`endif

endmodule
